// File: rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared constants and controller/datapath interface types for the
// trial division prime test core.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int VALUE_BITS = 31;
  // Divisor width: covers sqrt of the largest value plus one wheel step.
  localparam int D_BITS     = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_BITS    = 2 * D_BITS;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  localparam int FIRST_DIVISOR = 5;
  localparam int WHEEL_STEP    = 6;
  localparam int PAIR_GAP      = 2;
  localparam int SMALL_PRIME   = 3;

  typedef enum logic [1:0] {
    SEL_THREE = 2'd0,
    SEL_D     = 2'd1,
    SEL_D2    = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic n_le1;
    logic n_le3;
    logic n_even;
    logic div_done;
    logic rem_zero;
    logic sq_gt_n;
  } dp_status_t;

endpackage

// File: rtl/trial_division_prime_test_core.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_core
// Primality test of one unsigned value by 6k +/- 1 trial division.
// ----------------------------------------------------------------------------
//
//  channel   ports                               transfer when
//  --------  ----------------------------------  ------------------------
//  input     start, busy, in_candidate           start && !busy
//  result    out_valid, out_tested_value,        out_valid (one cycle,
//            out_is_prime                        cannot be stalled)
//
//  Steps: values up to three and even values are settled in the check state
//  that follows the start transfer, and the result strobe is registered from
//  it. Otherwise one mod-3 remainder, then per divisor pair one bound check
//  and two remainders of VALUE_BITS dividend bits each, all on the single
//  bit-serial remainder unit; the largest 31-bit primes take about 7700
//  divisor pairs.
//  Reset: synchronous, active low; clears controller and strobe state.
//  Stalls: busy stays high until the result strobe; the receiver cannot
//  hold results off, so a transfer on the result side always completes.
//
module trial_division_prime_test_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [tdpt_pkg::VALUE_BITS-1:0] in_candidate,
  output logic                            out_valid,
  output logic [tdpt_pkg::VALUE_BITS-1:0] out_tested_value,
  output logic                            out_is_prime
);

  tdpt_pkg::ctrl_cmd_t  cmd;
  tdpt_pkg::dp_status_t status;

  // Sequencer: accepts a start transfer only while idle, then drives the
  // datapath step by step until the answer is known.
  tdpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .res_valid (out_valid),
    .res_prime (out_is_prime)
  );

  // Datapath: holds the candidate, which also serves as the echo on the
  // result side; it is reloaded only at the next start transfer.
  tdpt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .candidate (in_candidate),
    .status    (status),
    .value     (out_tested_value)
  );

endmodule

// File: rtl/tdpt_div.sv
// ----------------------------------------------------------------------------
// tdpt_div
// Restoring remainder unit: one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module tdpt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tdpt_pkg::VALUE_BITS-1:0] dividend,
  input  logic [tdpt_pkg::D_BITS-1:0]   divisor,
  output logic                          done,
  output logic [tdpt_pkg::D_BITS-1:0]   rem
);

  localparam int VB = tdpt_pkg::VALUE_BITS;
  localparam int DB = tdpt_pkg::D_BITS;
  localparam int CB = tdpt_pkg::CNT_BITS;

  logic [VB-1:0] dvd_r;
  logic [DB-1:0] dsr_r;
  logic [DB-1:0] rem_r;
  logic [CB-1:0] cnt_r;
  logic          run_r;
  logic          done_r;

  logic [DB:0]   partial;
  logic [DB:0]   diff;
  logic [DB-1:0] rem_nxt;

  always_comb begin
    partial = {rem_r, dvd_r[VB-1]};
    diff    = partial - {1'b0, dsr_r};
    if (partial >= {1'b0, dsr_r}) begin
      rem_nxt = diff[DB-1:0];
    end else begin
      rem_nxt = partial[DB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CB'(VB - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[VB-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: rtl/tdpt_datapath.sv
// ----------------------------------------------------------------------------
// tdpt_datapath
// Candidate, wheel divisor and its running square, plus the remainder unit.
// ----------------------------------------------------------------------------
module tdpt_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tdpt_pkg::ctrl_cmd_t             cmd,
  input  logic [tdpt_pkg::VALUE_BITS-1:0] candidate,
  output tdpt_pkg::dp_status_t            status,
  output logic [tdpt_pkg::VALUE_BITS-1:0] value
);

  localparam int VB = tdpt_pkg::VALUE_BITS;
  localparam int DB = tdpt_pkg::D_BITS;
  localparam int SB = tdpt_pkg::SQ_BITS;
  localparam int FIRST_SQ = tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR;
  localparam int STEP_SQ  = tdpt_pkg::WHEEL_STEP * tdpt_pkg::WHEEL_STEP;
  localparam int STEP_2X  = 2 * tdpt_pkg::WHEEL_STEP;

  logic [VB-1:0] n_r;
  logic [DB-1:0] d_r;
  logic [SB-1:0] sq_r;

  logic [DB-1:0] divisor;
  logic          div_done;
  logic [DB-1:0] div_rem;

  always_comb begin
    case (cmd.div_sel)
      tdpt_pkg::SEL_THREE: divisor = DB'(tdpt_pkg::SMALL_PRIME);
      tdpt_pkg::SEL_D:     divisor = d_r;
      tdpt_pkg::SEL_D2:    divisor = d_r + DB'(tdpt_pkg::PAIR_GAP);
      default:             divisor = d_r;
    endcase
  end

  // (d + 6)^2 = d^2 + 12 d + 36
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r  <= candidate;
      d_r  <= DB'(tdpt_pkg::FIRST_DIVISOR);
      sq_r <= SB'(FIRST_SQ);
    end else if (cmd.advance) begin
      d_r  <= d_r + DB'(tdpt_pkg::WHEEL_STEP);
      sq_r <= sq_r + {{(SB-DB){1'b0}}, d_r} * SB'(STEP_2X) + SB'(STEP_SQ);
    end
  end

  tdpt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (n_r),
    .divisor  (divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    status.n_le1    = (n_r <= VB'(1));
    status.n_le3    = (n_r <= VB'(3));
    status.n_even   = ~n_r[0];
    status.div_done = div_done;
    status.rem_zero = (div_rem == '0);
    status.sq_gt_n  = (sq_r > {{(SB-VB){1'b0}}, n_r});
  end

  assign value = n_r;

endmodule

// File: rtl/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Sequencer: small-value checks, mod 3, then the d / d+2 wheel loop.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  tdpt_pkg::dp_status_t status,
  output tdpt_pkg::ctrl_cmd_t  cmd,
  output logic                 busy,
  output logic                 res_valid,
  output logic                 res_prime
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_MOD3  = 6'b000100,
    ST_BOUND = 6'b001000,
    ST_DIVA  = 6'b010000,
    ST_DIVB  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;
  logic   prime_r, prime_nxt;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = 1'b0;
    prime_nxt     = prime_r;
    cmd.load      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = tdpt_pkg::SEL_THREE;
    cmd.advance   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.n_le1 || status.n_even) begin
          // zero, one and even values; two is caught below first
          if (!status.n_le1 && status.n_le3) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b1;
          end else begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end else if (status.n_le3) begin
          valid_nxt = 1'b1;
          prime_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = tdpt_pkg::SEL_THREE;
          state_nxt     = ST_MOD3;
        end
      end
      ST_MOD3: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_BOUND;
          end
        end
      end
      ST_BOUND: begin
        if (status.sq_gt_n) begin
          valid_nxt = 1'b1;
          prime_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = tdpt_pkg::SEL_D;
          state_nxt     = ST_DIVA;
        end
      end
      ST_DIVA: begin
        cmd.div_sel = tdpt_pkg::SEL_D2;
        if (status.div_done) begin
          if (status.rem_zero) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIVB;
          end
        end
      end
      ST_DIVB: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = ST_BOUND;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prime_r <= prime_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = valid_r;
  assign res_prime = prime_r;

  a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r)
    else $error("result strobe held longer than one cycle");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> state_r == ST_IDLE)
    else $error("result strobe outside idle");

  a_div_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !status.div_done)
    else $error("remainder unit done right after start");

  a_advance_loops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |=> state_r == ST_BOUND)
    else $error("divisor advanced without returning to bound check");

endmodule
